>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge, skipped while in reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// condition that must never be seen on a rising edge
`define ASSERT_NEVER(label, clk, rst, cond) \
   `ASSERT_CLK(label, clk, rst, !(cond))

`endif

>>> rtl/core/bhar_pkg.sv
package bhar_pkg;

   localparam int TIME_W = 32;
   localparam int CFG_W  = 16;
   localparam int MODE_W = 2;

   localparam logic [MODE_W-1:0] MODE_RELEASED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PRESSED  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HELD     = 2'd2;

   localparam logic REG_HOLD_MS   = 1'b0;
   localparam logic REG_REPEAT_MS = 1'b1;

   localparam logic [CFG_W-1:0] HOLD_MS_RESET   = 16'd1000;
   localparam logic [CFG_W-1:0] REPEAT_MS_RESET = 16'd200;

   typedef struct packed {
      logic [CFG_W-1:0] hold_ms;
      logic [CFG_W-1:0] repeat_ms;
   } cfg_type;

   typedef struct packed {
      logic              level;
      logic [TIME_W-1:0] now_ms;
   } sample_type;

   typedef struct packed {
      logic [MODE_W-1:0] phase;
      logic [TIME_W-1:0] press_start_ms;
      logic              first_step_done;
      logic [TIME_W-1:0] last_repeat_ms;
   } state_type;

   typedef struct packed {
      logic              step_pulse;
      logic [MODE_W-1:0] button_mode;
   } result_type;

endpackage

>>> rtl/core/bhar_csr.sv
module bhar_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [bhar_pkg::CFG_W-1:0] csr_wdata,
   output bhar_pkg::cfg_type       cfg
);
   import bhar_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_HOLD_MS:   cfg_in.hold_ms   = csr_wdata;
            REG_REPEAT_MS: cfg_in.repeat_ms = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ms   <= HOLD_MS_RESET;
         cfg_ff.repeat_ms <= REPEAT_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/bhar_step.sv
module bhar_step (
   input  bhar_pkg::cfg_type    cfg,
   input  bhar_pkg::sample_type sample,
   input  bhar_pkg::state_type  state,
   output bhar_pkg::state_type  state_next,
   output bhar_pkg::result_type result
);
   import bhar_pkg::*;

   logic [TIME_W-1:0] since_press;
   logic [TIME_W-1:0] since_repeat;
   logic              hold_elapsed;
   logic              repeat_elapsed;
   logic              pulse;

   // differences wrap modulo 2^32
   assign since_press    = sample.now_ms - state.press_start_ms;
   assign since_repeat   = sample.now_ms - state.last_repeat_ms;
   assign hold_elapsed   = since_press  > {{(TIME_W-CFG_W){1'b0}}, cfg.hold_ms};
   assign repeat_elapsed = since_repeat > {{(TIME_W-CFG_W){1'b0}}, cfg.repeat_ms};

   always_comb begin
      state_next = state;
      pulse      = 1'b0;
      if (!sample.level) begin
         state_next.phase = MODE_RELEASED;
      end else begin
         unique case (state.phase)
            MODE_PRESSED: begin
               if (!state.first_step_done) begin
                  pulse                      = 1'b1;
                  state_next.first_step_done = 1'b1;
               end else if (hold_elapsed) begin
                  state_next.phase           = MODE_HELD;
                  state_next.press_start_ms  = sample.now_ms;
                  state_next.first_step_done = 1'b0;
                  state_next.last_repeat_ms  = '0;
               end
            end
            MODE_HELD: begin
               if (repeat_elapsed) begin
                  pulse                     = 1'b1;
                  state_next.last_repeat_ms = sample.now_ms;
               end
            end
            default: begin
               // released, and the unused code
               state_next.phase           = MODE_PRESSED;
               state_next.press_start_ms  = sample.now_ms;
               state_next.first_step_done = 1'b0;
            end
         endcase
      end
   end

   assign result.step_pulse  = pulse;
   assign result.button_mode = state_next.phase;

endmodule

>>> rtl/core/button_hold_auto_repeat_core.sv
// channel | dir | tdata (lsb up)                      | handshake
// req     | in  | level[0], now_ms[32:1], pad [39:33] | req_tvalid/req_tready
// rsp     | out | step_pulse[0], button_mode[2:1]     | rsp_tvalid/rsp_tready
// csr     | in  | index 0 hold_ms, 1 repeat_ms        | csr_we, no wait
//
// One word per cycle sustained while rsp is not stalled; a word accepted on req reaches rsp
// through the input register, then one pass of the step logic into the output register.
// A stalled rsp holds one result while one more word waits in the input register.
// Reset (synchronous): button released, stored times zero, hold_ms 1000,
// repeat_ms 200, both channels empty.
`include "assert_macros.svh"

module button_hold_auto_repeat_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // level, now_ms, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // step_pulse, button_mode, zero pad
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [bhar_pkg::CFG_W-1:0] csr_wdata
);
   import bhar_pkg::*;

   cfg_type    cfg;
   sample_type in_data_ff, in_data_in;
   logic       in_valid_ff, in_valid_in;
   state_type  state_ff, state_in, state_next;
   result_type result;
   result_type out_data_ff, out_data_in;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       req_fire;

   bhar_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bhar_step u_step (
      .cfg        (cfg),
      .sample     (in_data_ff),
      .state      (state_ff),
      .state_next (state_next),
      .result     (result)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      state_in     = state_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         out_data_in  = result;
         state_in     = state_next;
      end
      if (req_fire) begin
         in_valid_in       = 1'b1;
         in_data_in.level  = req_tdata[0];
         in_data_in.now_ms = req_tdata[TIME_W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_data_ff.button_mode, out_data_ff.step_pulse};

   `ASSERT_NEVER(a_no_pulse_released, clock, reset,
      out_valid_ff && out_data_ff.step_pulse && out_data_ff.button_mode == MODE_RELEASED)
   `ASSERT_CLK(a_latch_no_pulse, clock, reset,
      advance && state_ff.phase == MODE_PRESSED && state_next.phase == MODE_HELD
         |-> !result.step_pulse)
   `ASSERT_CLK(a_waiting_word_kept, clock, reset,
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff) && $stable(state_ff))

endmodule

>>> tb/tb_button_hold_auto_repeat_core.sv
module tb_button_hold_auto_repeat_core;
   import bhar_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [39:0]       req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;
   logic              csr_we = 1'b0;
   logic              csr_index = REG_HOLD_MS;
   logic [CFG_W-1:0]  csr_wdata = '0;

   int send_idle = 0;
   int rcv_idle = 0;
   int hold_cfg = int'(HOLD_MS_RESET);
   int rep_cfg = int'(REPEAT_MS_RESET);
   int sent_words = 0;
   int cycles = 0;

   class repeat_tracker;
      logic [CFG_W-1:0]  hold_ms;
      logic [CFG_W-1:0]  repeat_ms;
      logic [MODE_W-1:0] mode;
      logic [TIME_W-1:0] press_at;
      logic [TIME_W-1:0] last_step_at;
      logic              first_step_done;
      result_type        due_steps[$];
      int                errors;

      function new();
         hold_ms = HOLD_MS_RESET;
         repeat_ms = REPEAT_MS_RESET;
         mode = MODE_RELEASED;
         press_at = '0;
         last_step_at = '0;
         first_step_done = 1'b0;
         errors = 0;
      endfunction

      function void write_reg(logic idx, logic [CFG_W-1:0] value);
         if (idx == REG_HOLD_MS) begin
            hold_ms = value;
         end else begin
            repeat_ms = value;
         end
      endfunction

      // work out the step and mode caused by one accepted sample
      function void note_sample(logic lvl, logic [TIME_W-1:0] now_ms);
         result_type        res;
         logic [TIME_W-1:0] since;
         res.step_pulse = 1'b0;
         if (!lvl) begin
            mode = MODE_RELEASED;
         end else begin
            case (mode)
               MODE_PRESSED: begin
                  since = now_ms - press_at;
                  if (!first_step_done) begin
                     res.step_pulse = 1'b1;
                     first_step_done = 1'b1;
                  end else if (since > {16'd0, hold_ms}) begin
                     mode = MODE_HELD;
                     press_at = now_ms;
                     first_step_done = 1'b0;
                     last_step_at = '0;
                  end
               end
               MODE_HELD: begin
                  since = now_ms - last_step_at;
                  if (since > {16'd0, repeat_ms}) begin
                     res.step_pulse = 1'b1;
                     last_step_at = now_ms;
                  end
               end
               default: begin
                  mode = MODE_PRESSED;
                  press_at = now_ms;
                  first_step_done = 1'b0;
               end
            endcase
         end
         res.button_mode = mode;
         due_steps.push_back(res);
      endfunction

      function void check_step(logic [7:0] word);
         result_type due;
         if (due_steps.size() == 0) begin
            $display("%0t unexpected word: expected none, actual %h", $time, word);
            errors++;
         end else begin
            due = due_steps.pop_front();
            if (word[0] !== due.step_pulse) begin
               $display("%0t step_pulse: expected %0d, actual %0d",
                        $time, due.step_pulse, word[0]);
               errors++;
            end
            if (word[2:1] !== due.button_mode) begin
               $display("%0t button_mode: expected %0d, actual %0d",
                        $time, due.button_mode, word[2:1]);
               errors++;
            end
         end
      endfunction
   endclass

   repeat_tracker tracker = new();

   button_hold_auto_repeat_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // level[0], now_ms[32:1], zero pad
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // step_pulse[0], button_mode[2:1], zero pad
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_idle);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tracker.note_sample(req_tdata[0], req_tdata[32:1]);
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_step(rsp_tdata);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] now_ms);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, now_ms, lvl};
      do @(posedge clock); while (!req_tready);
      sent_words++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.due_steps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_timing(input int hold, input int rep);
      csr_we <= 1'b1;
      csr_index <= REG_HOLD_MS;
      csr_wdata <= hold[CFG_W-1:0];
      @(posedge clock);
      tracker.write_reg(REG_HOLD_MS, hold[CFG_W-1:0]);
      csr_index <= REG_REPEAT_MS;
      csr_wdata <= rep[CFG_W-1:0];
      @(posedge clock);
      tracker.write_reg(REG_REPEAT_MS, rep[CFG_W-1:0]);
      csr_we <= 1'b0;
      hold_cfg = hold;
      rep_cfg = rep;
   endtask

   // low word, then a run of high words with steps chosen around the thresholds
   task automatic run_press(input int highs);
      logic [TIME_W-1:0] t;
      int                k;
      case ($urandom_range(3))
         0: t = $urandom_range(0, 500);
         1: t = 32'hFFFF_FFFF - $urandom_range(0, 3000);
         default: t = $urandom;
      endcase
      send_sample(1'b0, t);
      for (k = 0; k < highs; k++) begin
         case ($urandom_range(9))
            0: t = t;
            1: t = t + hold_cfg;
            2: t = t + hold_cfg + 1;
            3: t = t + rep_cfg;
            4: t = t + rep_cfg + 1;
            5, 6: t = t + $urandom_range(0, rep_cfg + 1);
            7: t = t + $urandom_range(0, hold_cfg + 2);
            8: t = t + $urandom;
            default: t = t + $urandom_range(1, 3);
         endcase
         send_sample(1'b1, t);
      end
   endtask

   initial begin
      int p;
      int goal;
      int k;
      send_idle = 36;
      rcv_idle = 49;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // press, first step, latch on the strict bound, repeats, wrap across zero
      send_sample(1'b0, 32'd0);
      send_sample(1'b1, 32'd10);
      send_sample(1'b1, 32'd10);
      send_sample(1'b1, 32'd1010);
      send_sample(1'b1, 32'd1011);
      send_sample(1'b1, 32'd1100);
      send_sample(1'b1, 32'd1300);
      send_sample(1'b1, 32'd1301);
      send_sample(1'b0, 32'd1302);
      send_sample(1'b1, 32'hFFFF_FFF0);
      send_sample(1'b1, 32'hFFFF_FFF0);
      send_sample(1'b1, 32'hFFFF_FFF0 + 32'd1008);
      send_sample(1'b1, 32'd150);
      send_sample(1'b1, 32'd201);
      send_sample(1'b1, 32'd401);
      send_sample(1'b1, 32'hFFFF_FFFF);
      send_sample(1'b1, 32'd100);
      send_sample(1'b1, 32'd200);
      send_sample(1'b0, 32'hFFFF_FFFF);
      send_sample(1'b1, 32'd5);
      send_sample(1'b0, 32'd6);
      send_sample(1'b1, 32'hAAAA_AAAA);
      send_sample(1'b1, 32'h5555_5555);

      for (p = 0; p < 6; p++) begin
         if (p > 0) begin
            drain();
            case (p)
               1: set_timing(0, 0);
               2: set_timing(65535, 65535);
               3: set_timing($urandom_range(1, 300), $urandom_range(1, 100));
               4: set_timing(0, 65535);
               default: set_timing(65535, 1);
            endcase
         end
         case (p / 2)
            0: begin
               send_idle = 36;
               rcv_idle = 49;
            end
            1: begin
               send_idle = 49;
               rcv_idle = 36;
            end
            default: begin
               send_idle = 0;
               rcv_idle = 0;
            end
         endcase
         goal = sent_words + 113;
         while (sent_words < goal) begin
            if ($urandom_range(9) < 8) begin
               run_press($urandom_range(1, 12));
            end else begin
               for (k = 0; k < $urandom_range(1, 4); k++) begin
                  send_sample(1'($urandom_range(1)), $urandom);
               end
            end
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      while (tracker.due_steps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.errors == 0 && tracker.due_steps.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
